>>> rtl/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, off while rst_n is low.
`define PBDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent required in the next cycle.
`define PBDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

>>> rtl/pbdc_pkg.sv
// Types, codes and helper functions of the distance constraint solver.
package pbdc_pkg;

    // Defaults for the top-level parameters
    localparam int VERTEX_COUNT_DEF  = 1024;
    localparam int FRACTION_BITS_DEF = 16;

    // Fixed field widths
    localparam int IDX_W  = 10;
    localparam int GAIN_W = 17;
    localparam logic [GAIN_W-1:0] GAIN_FULL = 17'd65536;

    // Operation codes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_EDGE   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;    // taken and dropped, no result

    // Result status codes
    localparam logic [2:0] STAT_WRITTEN    = 3'd0;
    localparam logic [2:0] STAT_READ       = 3'd1;
    localparam logic [2:0] STAT_APPLIED    = 3'd2;
    localparam logic [2:0] STAT_WEIGHTLESS = 3'd3;
    localparam logic [2:0] STAT_COINCIDENT = 3'd4;

    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  vertex_index;
        logic [IDX_W-1:0]  edge_first;
        logic [IDX_W-1:0]  edge_second;
        logic signed [31:0] load_x;
        logic signed [31:0] load_y;
        logic signed [31:0] load_z;
        logic [31:0]       load_inverse_mass;
        logic [30:0]       rest_length;
    } cmd_t;

    typedef struct packed {
        logic [2:0]        status;
        logic signed [31:0] read_x;
        logic signed [31:0] read_y;
        logic signed [31:0] read_z;
        logic [31:0]       read_inverse_mass;
        logic              saturated;
    } rsp_t;

    // Clamp to 32-bit signed range; MSB of the result is the clamp flag
    function automatic logic [32:0] sat32(input logic signed [36:0] v);
        logic [32:0] r;
        if (v > 37'sd2147483647)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -37'sd2147483648)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

endpackage

>>> rtl/pbd_distance_constraint_solver.sv
// Position based dynamics distance constraint solver with its vertex store.
//
// Use: transactions enter on cmd (cmd_valid/cmd_ready) and each one that is
// a write, read or edge gives one result on rsp (rsp_valid/rsp_ready).
// Op code 3 is taken and dropped. The user writes the gain register through
// gain_we/gain_wdata only while the block is idle; the block itself does not
// enforce this. A write or a read goes through the emit state, which loads
// the result and raises rsp_valid once the previous result has left.
// An edge runs on one shared multiplier, one square-root digit unit and one
// radix-2 divider, through the 34-step square root and five divisions.
// Skipped edges finish after the weight test or the square root.
// cmd_ready is high only while the sequencer is idle; one transaction is in
// work at a time. The result sits in an output register, so the next
// transaction is taken while rsp waits; a stalled receiver holds the block
// only once a second result is ready to leave.
// Reset: clears control state and sets the gain to full. The vertex store
// is not cleared; entries hold garbage until written.
module pbd_distance_constraint_solver #(
    parameter int VERTEX_COUNT  = pbdc_pkg::VERTEX_COUNT_DEF,
    parameter int FRACTION_BITS = pbdc_pkg::FRACTION_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  pbdc_pkg::cmd_t              cmd,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output pbdc_pkg::rsp_t              rsp,
    input  logic                        gain_we,
    input  logic [pbdc_pkg::GAIN_W-1:0] gain_wdata
);

    localparam int F  = FRACTION_BITS;
    localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int QW = F + 1;          // quotient bits
    localparam int MW = 33;             // dividend magnitude bits
    localparam int NW = MW + F + 1;     // dividend after scale and rounding bias
    localparam int DW = 33;             // divisor bits

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LA   = 4'd1;
    localparam logic [3:0] S_LB   = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_SQ   = 4'd4;
    localparam logic [3:0] S_SQRT = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_MUL  = 4'd7;
    localparam logic [3:0] S_WA   = 4'd8;
    localparam logic [3:0] S_WB   = 4'd9;
    localparam logic [3:0] S_EMIT = 4'd10;

    // Index wrap by compare and subtract of shifted vertex counts
    function automatic logic [AW-1:0] wrap_index(input logic [pbdc_pkg::IDX_W-1:0] v);
        logic [pbdc_pkg::IDX_W-1:0] r;
        r = v;
        for (int s = pbdc_pkg::IDX_W - 1; s >= 0; s--) begin
            if ((VERTEX_COUNT << s) < (1 << pbdc_pkg::IDX_W)) begin
                if (r >= pbdc_pkg::IDX_W'(VERTEX_COUNT << s))
                    r = r - pbdc_pkg::IDX_W'(VERTEX_COUNT << s);
            end
        end
        return AW'(r);
    endfunction

    // Control registers
    logic [3:0]  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [2:0]  dsel_reg, dsel_next;
    logic [2:0]  status_reg, status_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic [pbdc_pkg::GAIN_W-1:0] stretch_gain_reg;

    // Vertex store and its registered read port
    logic [31:0] mem_x [VERTEX_COUNT];
    logic [31:0] mem_y [VERTEX_COUNT];
    logic [31:0] mem_z [VERTEX_COUNT];
    logic [31:0] mem_m [VERTEX_COUNT];
    logic [31:0] rd_x_reg, rd_y_reg, rd_z_reg, rd_m_reg;
    logic          rd_en, wr_en, wr_m_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]   wr_x, wr_y, wr_z;

    // Datapath registers
    logic [AW-1:0]      a_reg, b_reg;
    logic [30:0]        rest_reg;
    logic signed [31:0] pa_reg [3];
    logic signed [31:0] pb_reg [3];
    logic [31:0]        wa_reg, wb_reg;
    logic [67:0]        sum_reg;
    logic [36:0]        sq_rem_reg;
    logic [33:0]        root_reg;
    logic [DW-1:0]      div_rem_reg;
    logic [QW-1:0]      num_reg, q_reg;
    logic [QW-1:0]      sa_reg, sb_reg, ga_reg, gb_reg;
    logic signed [F+1:0] u_reg [3];
    logic signed [35:0] step_a_reg, step_b_reg;
    logic signed [69:0] prod_reg;
    logic [31:0]        na_reg [3];
    logic [31:0]        nb_reg [3];
    logic               sat_reg;
    pbdc_pkg::rsp_t     rsp_reg;

    logic cmd_fire;
    assign cmd_ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Edge differences and magnitudes
    logic signed [32:0] d [3];
    logic [32:0]        dmag [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d[k]    = 33'(pa_reg[k]) - 33'(pb_reg[k]);
            dmag[k] = d[k][32] ? 33'(-d[k]) : 33'(d[k]);
        end
    end

    logic [32:0]        wsum;
    logic [32:0]        edge_len;
    logic signed [34:0] err;
    logic [pbdc_pkg::GAIN_W-1:0] gain_eff;
    assign wsum     = 33'(wa_reg) + 33'(wb_reg);
    assign edge_len = root_reg[32:0];
    assign err      = $signed({2'b00, edge_len}) - $signed({4'b0000, rest_reg});
    assign gain_eff = (stretch_gain_reg > pbdc_pkg::GAIN_FULL) ? pbdc_pkg::GAIN_FULL
                                                                : stretch_gain_reg;

    // Shared multiplier operand select
    logic [1:0]         sq_k, mul_k, div_k;
    logic signed [35:0] mul_a;
    logic signed [33:0] mul_b;
    logic [3:0]         mul_idx;
    assign sq_k    = cnt_reg[1:0];
    assign mul_idx = 4'(cnt_reg - 6'd4);
    assign mul_k   = mul_idx[2:1];
    assign div_k   = 2'(dsel_reg - 3'd2);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ:
            begin
                mul_a = $signed({3'b000, dmag[sq_k]});
                mul_b = $signed({1'b0, dmag[sq_k]});
            end
            S_MUL:
            begin
                case (cnt_reg)
                    6'd0:
                    begin
                        mul_a = $signed(36'(sa_reg));
                        mul_b = $signed(34'(gain_eff));
                    end
                    6'd1:
                    begin
                        mul_a = $signed(36'(sb_reg));
                        mul_b = $signed(34'(gain_eff));
                    end
                    6'd2:
                    begin
                        mul_a = 36'(err);
                        mul_b = $signed(34'(ga_reg));
                    end
                    6'd3:
                    begin
                        mul_a = 36'(err);
                        mul_b = $signed(34'(gb_reg));
                    end
                    default:
                    begin
                        mul_a = mul_idx[0] ? step_b_reg : step_a_reg;
                        mul_b = 34'(u_reg[mul_k]);
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rounding of the registered product, ties away from zero
    logic [69:0]        prod_mag, r16_mag, rf_mag;
    logic signed [35:0] rf;
    logic signed [36:0] new_a, new_b;
    logic [32:0]        clamp_a, clamp_b;
    logic [3:0]         cap_idx;
    logic [1:0]         cap_k;
    assign prod_mag = prod_reg[69] ? 70'(-prod_reg) : 70'(prod_reg);
    assign r16_mag  = (prod_mag + (70'(1) << 15)) >> 16;
    assign rf_mag   = (prod_mag + (70'(1) << (F - 1))) >> F;
    assign rf       = prod_reg[69] ? -$signed(rf_mag[35:0]) : $signed(rf_mag[35:0]);
    assign cap_idx  = 4'(cnt_reg - 6'd5);
    assign cap_k    = cap_idx[2:1];
    assign new_a    = 37'(pa_reg[cap_k]) - 37'(rf);
    assign new_b    = 37'(pb_reg[cap_k]) + 37'(rf);
    assign clamp_a  = pbdc_pkg::sat32(new_a);
    assign clamp_b  = pbdc_pkg::sat32(new_b);

    // Square root digit step
    logic [36:0] sq_rem2, sq_trial, sq_diff;
    logic        sq_ge;
    logic [33:0] root_step;
    assign sq_rem2   = {sq_rem_reg[34:0], sum_reg[67:66]};
    assign sq_trial  = {1'b0, root_reg, 2'b01};
    assign sq_ge     = (sq_rem2 >= sq_trial);
    assign sq_diff   = sq_rem2 - sq_trial;
    assign root_step = {root_reg[32:0], sq_ge};

    // Divider operands and restoring step
    logic [MW-1:0] div_m;
    logic [DW-1:0] div_den;
    logic [NW-1:0] div_init;
    logic [DW:0]   div_rem2, div_diff;
    logic          div_ge;
    logic [QW-1:0] q_full;
    always_comb
    begin
        case (dsel_reg)
            3'd0:    div_m = {1'b0, wa_reg};
            3'd1:    div_m = {1'b0, wb_reg};
            default: div_m = dmag[div_k];
        endcase
        div_den = (dsel_reg < 3'd2) ? wsum : edge_len;
    end
    assign div_init = (NW'(div_m) << F) + NW'(div_den >> 1);
    assign div_rem2 = {div_rem_reg, num_reg[QW-1]};
    assign div_ge   = (div_rem2 >= {1'b0, div_den});
    assign div_diff = div_rem2 - {1'b0, div_den};
    assign q_full   = {q_reg[QW-2:0], div_ge};

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dsel_next      = dsel_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd.op)
                        pbdc_pkg::OP_WRITE:
                        begin
                            status_next = pbdc_pkg::STAT_WRITTEN;
                            state_next  = S_EMIT;
                        end
                        pbdc_pkg::OP_READ:
                        begin
                            status_next = pbdc_pkg::STAT_READ;
                            state_next  = S_EMIT;
                        end
                        pbdc_pkg::OP_EDGE:
                            state_next = S_LA;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_LA:
                state_next = S_LB;
            S_LB:
                state_next = S_CHK;
            S_CHK:
            begin
                cnt_next = '0;
                if (wsum == '0)
                begin
                    status_next = pbdc_pkg::STAT_WEIGHTLESS;
                    state_next  = S_EMIT;
                end
                else
                    state_next = S_SQ;
            end
            S_SQ:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd3)
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd33)
                begin
                    cnt_next   = '0;
                    dsel_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (dsel_reg == 3'd0 && cnt_reg == 6'd0 && root_reg == '0)
                begin
                    status_next = pbdc_pkg::STAT_COINCIDENT;
                    state_next  = S_EMIT;
                end
                else if (cnt_reg == 6'(QW))
                begin
                    cnt_next  = '0;
                    dsel_next = dsel_reg + 3'd1;
                    if (dsel_reg == 3'd4)
                        state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd10)
                begin
                    cnt_next   = '0;
                    state_next = S_WA;
                end
            end
            S_WA:
                state_next = S_WB;
            S_WB:
            begin
                status_next = pbdc_pkg::STAT_APPLIED;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            dsel_reg         <= '0;
            status_reg       <= pbdc_pkg::STAT_WRITTEN;
            rsp_valid_reg    <= 1'b0;
            stretch_gain_reg <= pbdc_pkg::GAIN_FULL;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            dsel_reg      <= dsel_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
            if (gain_we)
                stretch_gain_reg <= gain_wdata;
        end
    end

    // Store port control
    assign rd_en   = (cmd_fire && (cmd.op == pbdc_pkg::OP_READ || cmd.op == pbdc_pkg::OP_EDGE))
                     || (state_reg == S_LA);
    assign rd_addr = (state_reg == S_LA) ? b_reg
                   : wrap_index((cmd.op == pbdc_pkg::OP_READ) ? cmd.vertex_index
                                                               : cmd.edge_first);
    assign wr_m_en = cmd_fire && (cmd.op == pbdc_pkg::OP_WRITE);
    assign wr_en   = wr_m_en || (state_reg == S_WA) || (state_reg == S_WB);

    always_comb
    begin
        case (state_reg)
            S_WA:
            begin
                wr_addr = a_reg;
                wr_x    = na_reg[0];
                wr_y    = na_reg[1];
                wr_z    = na_reg[2];
            end
            S_WB:
            begin
                wr_addr = b_reg;
                wr_x    = nb_reg[0];
                wr_y    = nb_reg[1];
                wr_z    = nb_reg[2];
            end
            default:
            begin
                wr_addr = wrap_index(cmd.vertex_index);
                wr_x    = cmd.load_x;
                wr_y    = cmd.load_y;
                wr_z    = cmd.load_z;
            end
        endcase
    end

    // Vertex store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
            mem_z[wr_addr] <= wr_z;
        end
        if (wr_m_en)
            mem_m[wr_addr] <= cmd.load_inverse_mass;
        if (rd_en)
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
            rd_z_reg <= mem_z[rd_addr];
            rd_m_reg <= mem_m[rd_addr];
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                a_reg    <= wrap_index(cmd.edge_first);
                b_reg    <= wrap_index(cmd.edge_second);
                rest_reg <= cmd.rest_length;
            end
            S_LA:
            begin
                pa_reg[0] <= rd_x_reg;
                pa_reg[1] <= rd_y_reg;
                pa_reg[2] <= rd_z_reg;
                wa_reg    <= rd_m_reg;
            end
            S_LB:
            begin
                pb_reg[0] <= rd_x_reg;
                pb_reg[1] <= rd_y_reg;
                pb_reg[2] <= rd_z_reg;
                wb_reg    <= rd_m_reg;
            end
            S_CHK:
            begin
                sum_reg    <= '0;
                sq_rem_reg <= '0;
                root_reg   <= '0;
                sat_reg    <= 1'b0;
            end
            S_SQ:
            begin
                if (cnt_reg != 6'd0)
                    sum_reg <= sum_reg + prod_reg[67:0];
            end
            S_SQRT:
            begin
                sum_reg    <= {sum_reg[65:0], 2'b00};
                sq_rem_reg <= sq_ge ? sq_diff : sq_rem2;
                root_reg   <= root_step;
            end
            S_DIV:
            begin
                if (cnt_reg == 6'd0)
                begin
                    div_rem_reg <= div_init[NW-1:QW];
                    num_reg     <= div_init[QW-1:0];
                    q_reg       <= '0;
                end
                else
                begin
                    div_rem_reg <= div_ge ? div_diff[DW-1:0] : div_rem2[DW-1:0];
                    num_reg     <= {num_reg[QW-2:0], 1'b0};
                    q_reg       <= q_full;
                    if (cnt_reg == 6'(QW))
                    begin
                        case (dsel_reg)
                            3'd0:    sa_reg <= q_full;
                            3'd1:    sb_reg <= q_full;
                            default: u_reg[div_k] <= d[div_k][32]
                                                     ? -$signed({1'b0, q_full})
                                                     : $signed({1'b0, q_full});
                        endcase
                    end
                end
            end
            S_MUL:
            begin
                case (cnt_reg)
                    6'd0: ;
                    6'd1: ga_reg     <= r16_mag[QW-1:0];
                    6'd2: gb_reg     <= r16_mag[QW-1:0];
                    6'd3: step_a_reg <= rf;
                    6'd4: step_b_reg <= rf;
                    default:
                    begin
                        if (cap_idx[0])
                        begin
                            nb_reg[cap_k] <= clamp_b[31:0];
                            sat_reg       <= sat_reg | clamp_b[32];
                        end
                        else
                        begin
                            na_reg[cap_k] <= clamp_a[31:0];
                            sat_reg       <= sat_reg | clamp_a[32];
                        end
                    end
                endcase
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_reg.status            <= status_reg;
                    rsp_reg.read_x            <= (status_reg == pbdc_pkg::STAT_READ) ? rd_x_reg : '0;
                    rsp_reg.read_y            <= (status_reg == pbdc_pkg::STAT_READ) ? rd_y_reg : '0;
                    rsp_reg.read_z            <= (status_reg == pbdc_pkg::STAT_READ) ? rd_z_reg : '0;
                    rsp_reg.read_inverse_mass <= (status_reg == pbdc_pkg::STAT_READ) ? rd_m_reg : '0;
                    rsp_reg.saturated         <= (status_reg == pbdc_pkg::STAT_APPLIED) && sat_reg;
                end
            end
            default: ;
        endcase
    end

    // Checks
    `include "assert_macros.svh"

    `PBDC_ASSERT_NEXT(a_edge_busy, cmd_fire && cmd.op == pbdc_pkg::OP_EDGE, !cmd_ready, "edge transaction did not hold off new commands")
    `PBDC_ASSERT(a_status_range, rsp_valid |-> rsp.status <= pbdc_pkg::STAT_COINCIDENT, "result status out of range")
    `PBDC_ASSERT(a_read_fields_zero, rsp_valid && rsp.status != pbdc_pkg::STAT_READ |-> rsp.read_x == '0 && rsp.read_inverse_mass == '0, "read fields set on a non-read result")

endmodule

>>> test/pbd_distance_constraint_solver_tb.sv
// Self-checking testbench for the distance constraint solver: directed and random traffic against a predictor.
`timescale 1ns / 100ps

module pbd_distance_constraint_solver_tb;

    localparam int VCOUNT      = pbdc_pkg::VERTEX_COUNT_DEF;
    localparam int FRAC        = pbdc_pkg::FRACTION_BITS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 200;

    logic                        clk;
    logic                        rst_n;
    logic                        cmd_valid;
    logic                        cmd_ready;
    pbdc_pkg::cmd_t              cmd;
    logic                        rsp_valid;
    logic                        rsp_ready;
    pbdc_pkg::rsp_t              rsp;
    logic                        gain_we;
    logic [pbdc_pkg::GAIN_W-1:0] gain_wdata;

    pbd_distance_constraint_solver dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .gain_we    (gain_we),
        .gain_wdata (gain_wdata)
    );

    // Vertex store mirror and expected responses
    class pbdc_scoreboard;
        int          pos_x [VCOUNT];
        int          pos_y [VCOUNT];
        int          pos_z [VCOUNT];
        int unsigned inv_mass [VCOUNT];
        logic [pbdc_pkg::GAIN_W-1:0] gain;
        pbdc_pkg::rsp_t pending_rsp [$];
        int          mismatches;

        function new();
            gain = pbdc_pkg::GAIN_FULL;
            mismatches = 0;
        endfunction

        // round(v / 2^s), ties away from zero
        function longint shr_near(longint v, int s);
            longint m;
            m = (v < 0) ? -v : v;
            m = (m + (longint'(1) <<< (s - 1))) >>> s;
            return (v < 0) ? -m : m;
        endfunction

        // round(num / den), den > 0, ties away from zero
        function longint div_near(longint num, longint den);
            longint m;
            m = (num < 0) ? -num : num;
            m = (m + den / 2) / den;
            return (num < 0) ? -m : m;
        endfunction

        function int clamp_pos(longint v, inout bit sat);
            if (v > 64'sd2147483647) begin
                sat = 1;
                return 32'h7FFF_FFFF;
            end
            if (v < -64'sd2147483648) begin
                sat = 1;
                return 32'h8000_0000;
            end
            return int'(v);
        endfunction

        // Project one edge in place, return its response
        function pbdc_pkg::rsp_t project_edge(int unsigned a, int unsigned b, longint rest);
            pbdc_pkg::rsp_t e;
            longint       pa [3], pb [3], d [3], na [3], nb [3];
            longint       wa, wb, wsum, edge_len, err, sa, sb, ga, gb, step_a, step_b, u, g;
            longint unsigned m, r, t;
            logic [127:0] sq;
            bit           sat;
            e = '0;
            sat = 0;
            pa[0] = pos_x[a]; pa[1] = pos_y[a]; pa[2] = pos_z[a];
            pb[0] = pos_x[b]; pb[1] = pos_y[b]; pb[2] = pos_z[b];
            wa = inv_mass[a];
            wb = inv_mass[b];
            wsum = wa + wb;
            if (wsum == 0) begin
                e.status = pbdc_pkg::STAT_WEIGHTLESS;
                return e;
            end
            sq = '0;
            for (int k = 0; k < 3; k++) begin
                d[k] = pa[k] - pb[k];
                m = (d[k] < 0) ? -d[k] : d[k];
                sq = sq + 128'(m) * 128'(m);
            end
            // bitwise floor square root
            r = 0;
            for (int bit_i = 34; bit_i >= 0; bit_i--) begin
                t = r | (64'd1 << bit_i);
                if (128'(t) * 128'(t) <= sq)
                    r = t;
            end
            edge_len = longint'(r);
            if (edge_len == 0) begin
                e.status = pbdc_pkg::STAT_COINCIDENT;
                return e;
            end
            g = (gain > pbdc_pkg::GAIN_FULL) ? longint'(pbdc_pkg::GAIN_FULL) : longint'(gain);
            err = edge_len - rest;
            sa = div_near(wa <<< FRAC, wsum);
            sb = div_near(wb <<< FRAC, wsum);
            ga = shr_near(sa * g, 16);
            gb = shr_near(sb * g, 16);
            step_a = shr_near(err * ga, FRAC);
            step_b = shr_near(err * gb, FRAC);
            for (int k = 0; k < 3; k++) begin
                u = div_near(d[k] * (longint'(1) <<< FRAC), edge_len);
                na[k] = clamp_pos(pa[k] - shr_near(step_a * u, FRAC), sat);
                nb[k] = clamp_pos(pb[k] + shr_near(step_b * u, FRAC), sat);
            end
            pos_x[a] = int'(na[0]); pos_y[a] = int'(na[1]); pos_z[a] = int'(na[2]);
            pos_x[b] = int'(nb[0]); pos_y[b] = int'(nb[1]); pos_z[b] = int'(nb[2]);
            e.status = pbdc_pkg::STAT_APPLIED;
            e.saturated = sat;
            return e;
        endfunction

        // Accepted command: update the mirror and queue the response
        function void note_cmd(pbdc_pkg::cmd_t c);
            pbdc_pkg::rsp_t e;
            e = '0;
            case (c.op)
                pbdc_pkg::OP_WRITE: begin
                    pos_x[c.vertex_index] = c.load_x;
                    pos_y[c.vertex_index] = c.load_y;
                    pos_z[c.vertex_index] = c.load_z;
                    inv_mass[c.vertex_index] = c.load_inverse_mass;
                    e.status = pbdc_pkg::STAT_WRITTEN;
                    pending_rsp.push_back(e);
                end
                pbdc_pkg::OP_READ: begin
                    e.status = pbdc_pkg::STAT_READ;
                    e.read_x = pos_x[c.vertex_index];
                    e.read_y = pos_y[c.vertex_index];
                    e.read_z = pos_z[c.vertex_index];
                    e.read_inverse_mass = inv_mass[c.vertex_index];
                    pending_rsp.push_back(e);
                end
                pbdc_pkg::OP_EDGE: begin
                    e = project_edge(32'(c.edge_first), 32'(c.edge_second),
                                     longint'(c.rest_length));
                    pending_rsp.push_back(e);
                end
                default: ;  // unused op, dropped by the block
            endcase
        endfunction

        // Accepted response: compare with the oldest expectation
        function void check_rsp(pbdc_pkg::rsp_t r);
            pbdc_pkg::rsp_t e;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: %p", r);
                return;
            end
            e = pending_rsp.pop_front();
            if (r.status !== e.status || r.read_x !== e.read_x || r.read_y !== e.read_y ||
                r.read_z !== e.read_z || r.read_inverse_mass !== e.read_inverse_mass ||
                r.saturated !== e.saturated) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response mismatch: expected %p actual %p", e, r);
            end
        endfunction
    endclass

    pbdc_scoreboard sb;
    bit          quiet;
    int          stall_count;
    int          ready_hold;
    bit          written [VCOUNT];
    int unsigned written_list [$];

    // Clock
    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Response checking and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (rsp_valid && rsp_ready)
                sb.check_rsp(rsp);
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT) begin
                $display("pbd_distance_constraint_solver regression: fail");
                $finish;
            end
        end
    end

    // Receiver backpressure in random bursts
    always @(negedge clk) begin
        if (quiet) begin
            rsp_ready = 1;
        end else if (ready_hold > 0) begin
            rsp_ready = 0;
            ready_hold--;
        end else if ($urandom_range(0, 5) == 0) begin
            rsp_ready = 0;
            ready_hold = $urandom_range(0, 6);
        end else begin
            rsp_ready = 1;
        end
    end

    task automatic send_cmd(input pbdc_pkg::cmd_t c);
        if (!quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 7)) @(negedge clk);
        cmd = c;
        cmd_valid = 1;
        do @(posedge clk); while (!cmd_ready);
        sb.note_cmd(c);
        @(negedge clk);
        cmd_valid = 0;
    endtask

    // Wait for every response, then let a dropped op finish
    task automatic drain();
        while (sb.pending_rsp.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_gain(input logic [pbdc_pkg::GAIN_W-1:0] g);
        drain();
        gain_wdata = g;
        gain_we = 1;
        sb.gain = g;
        @(negedge clk);
        gain_we = 0;
    endtask

    function automatic void mark_written(int unsigned idx);
        if (!written[idx]) begin
            written[idx] = 1;
            written_list.push_back(idx);
        end
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1 << 19) - (1 << 18);
            1: return $urandom_range(0, 1 << 25) - (1 << 24);
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd65536;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_rest();
        case ($urandom_range(0, 4))
            0: return 31'd0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom_range(0, 1 << 20));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic pbdc_pkg::cmd_t write_cmd(int unsigned idx, logic [31:0] x,
                                                 logic [31:0] y, logic [31:0] z,
                                                 logic [31:0] w);
        pbdc_pkg::cmd_t c;
        c = pbdc_pkg::cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        c.op = pbdc_pkg::OP_WRITE;
        c.vertex_index = pbdc_pkg::IDX_W'(idx);
        c.load_x = x;
        c.load_y = y;
        c.load_z = z;
        c.load_inverse_mass = w;
        mark_written(idx);
        return c;
    endfunction

    function automatic pbdc_pkg::cmd_t edge_cmd(int unsigned a, int unsigned b,
                                                logic [30:0] rest);
        pbdc_pkg::cmd_t c;
        c = pbdc_pkg::cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        c.op = pbdc_pkg::OP_EDGE;
        c.edge_first = pbdc_pkg::IDX_W'(a);
        c.edge_second = pbdc_pkg::IDX_W'(b);
        c.rest_length = rest;
        return c;
    endfunction

    function automatic pbdc_pkg::cmd_t read_cmd(int unsigned idx);
        pbdc_pkg::cmd_t c;
        c = pbdc_pkg::cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        c.op = pbdc_pkg::OP_READ;
        c.vertex_index = pbdc_pkg::IDX_W'(idx);
        return c;
    endfunction

    // One random transaction; reads and edges only touch written vertices
    function automatic pbdc_pkg::cmd_t rand_cmd();
        pbdc_pkg::cmd_t c;
        int unsigned pick, a, b;
        pick = $urandom_range(0, 99);
        if (written_list.size() < 2 || pick < 30) begin
            a = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, VCOUNT - 1);
            return write_cmd(a, rand_coord(), rand_coord(), rand_coord(), rand_mass());
        end
        a = written_list[$urandom_range(0, written_list.size() - 1)];
        b = written_list[$urandom_range(0, written_list.size() - 1)];
        if (pick < 78)
            return edge_cmd(a, ($urandom_range(0, 19) == 0) ? a : b, rand_rest());
        if (pick < 96)
            return read_cmd(a);
        c = pbdc_pkg::cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        c.op = pbdc_pkg::OP_UNUSED;
        return c;
    endfunction

    // Main sequence
    initial begin
        logic [pbdc_pkg::GAIN_W-1:0] gains [6];
        pbdc_pkg::cmd_t noise;
        sb = new();
        quiet = 0;
        stall_count = 0;
        ready_hold = 0;
        rst_n = 0;
        cmd_valid = 0;
        cmd = '0;
        rsp_ready = 0;
        gain_we = 0;
        gain_wdata = '0;
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: basic edge, weightless, coincident, saturation, extremes
        send_cmd(write_cmd(0, 32'd0, 32'd0, 32'd0, 32'd65536));
        send_cmd(write_cmd(1, 32'd3 << 16, 32'd4 << 16, 32'd0, 32'd65536));
        send_cmd(edge_cmd(0, 1, 31'd0));
        send_cmd(read_cmd(0));
        send_cmd(read_cmd(1));
        send_cmd(write_cmd(2, 32'd100, 32'd0, 32'd0, 32'd0));
        send_cmd(write_cmd(3, 32'd0, 32'd100, 32'd0, 32'd0));
        send_cmd(edge_cmd(2, 3, 31'd5));
        send_cmd(edge_cmd(0, 0, 31'd7));
        send_cmd(write_cmd(4, 32'd0, 32'd0, 32'd0, 32'd1));
        send_cmd(edge_cmd(0, 4, 31'd1 << 16));
        send_cmd(write_cmd(5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_cmd(write_cmd(6, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0));
        send_cmd(edge_cmd(5, 6, 31'd0));
        send_cmd(write_cmd(7, 32'h7FFF_FF00, 32'd0, 32'd0, 32'hFFFF_FFFF));
        send_cmd(write_cmd(8, 32'h7FFF_FE00, 32'd0, 32'd0, 32'hFFFF_FFFF));
        send_cmd(edge_cmd(7, 8, 31'h7FFF_FFFF));
        send_cmd(read_cmd(5));
        send_cmd(read_cmd(7));
        noise = pbdc_pkg::cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        noise.op = pbdc_pkg::OP_UNUSED;
        send_cmd(noise);
        send_cmd(write_cmd(VCOUNT - 1, 32'hFFFF_FFFF, 32'd1, 32'h8000_0001, 32'd1));
        send_cmd(read_cmd(VCOUNT - 1));
        send_cmd(edge_cmd(VCOUNT - 1, 1, 31'd2 << 16));

        // Random phases at several gains; the last runs without idling
        gains[0] = 17'd0;
        gains[1] = 17'h1FFFF;
        gains[2] = 17'd32768;
        gains[3] = 17'd1;
        gains[4] = 17'd65535;
        gains[5] = pbdc_pkg::GAIN_FULL;
        for (int ph = 0; ph < 6; ph++) begin
            set_gain(gains[ph]);
            quiet = (ph == 5);
            for (int i = 0; i < 150; i++) begin
                if (i == 75 && ph == 2)
                    drain();
                send_cmd(rand_cmd());
            end
        end

        drain();
        if (sb.mismatches == 0 && sb.pending_rsp.size() == 0)
            $display("pbd_distance_constraint_solver regression: pass");
        else
            $display("pbd_distance_constraint_solver regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/pbdc_pkg.sv
rtl/pbd_distance_constraint_solver.sv
test/pbd_distance_constraint_solver_tb.sv
